// ----- sv/isg_pkg.sv -----
// Shared types and codes for the inverse-square gravity accumulator.
// Used by isg_iter, isg_mac, the top level and the checker; no dependencies.
`default_nettype none
package isg_pkg;
  localparam int MAX_ATTRACTORS_DEF = 16;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  typedef struct packed {
    logic       go;
    logic       op;
    logic [6:0] n;
  } iter_req_t;

  typedef struct packed {
    logic go;
    logic clr;
    logic sh32;
  } mac_req_t;
endpackage
`default_nettype wire

// ----- sv/isg_iter.sv -----
// Shared iterative unit: restoring divide (n quotient bits) or integer square root.
// One bit per cycle. Depends on isg_pkg.
`default_nettype none
module isg_iter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire isg_pkg::iter_req_t req,
  input  wire logic [63:0]       a,
  input  wire logic [63:0]       b,
  output logic                   done,
  output logic [63:0]            res
);
  import isg_pkg::*;

  logic        run;
  logic        mode;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] dq;
  logic [63:0] dv;
  logic [31:0] root;
  logic [64:0] r2;
  logic [35:0] r4;
  logic [35:0] trial;

  assign r2    = {rem, dq[63]};
  assign r4    = {rem[33:0], dq[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign res   = (mode == OP_DIV) ? dq : {32'd0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (req.go) begin
      done <= 1'b0;
      run  <= 1'b1;
      mode <= req.op;
      dv   <= b;
      root <= '0;
      if (req.op == OP_DIV) begin
        rem <= a >> req.n;
        dq  <= a << (7'd64 - req.n);
        cnt <= req.n;
      end else begin
        rem <= '0;
        dq  <= a;
        cnt <= 7'd32;
      end
    end else if (run) begin
      cnt  <= cnt - 7'd1;
      done <= (cnt == 7'd1);
      if (cnt == 7'd1) begin
        run <= 1'b0;
      end
      if (mode == OP_DIV) begin
        if (r2 >= {1'b0, dv}) begin
          rem <= 64'(r2 - {1'b0, dv});
          dq  <= {dq[62:0], 1'b1};
        end else begin
          rem <= r2[63:0];
          dq  <= {dq[62:0], 1'b0};
        end
      end else begin
        if (r4 >= trial) begin
          rem  <= 64'(r4 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= 64'(r4);
          root <= {root[30:0], 1'b0};
        end
        dq <= {dq[61:0], 2'b00};
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- sv/isg_mac.sv -----
// Shared multiply-accumulate: registered 33x33 product, then accumulate with
// optional 32-bit left shift. Depends on isg_pkg.
`default_nettype none
module isg_mac (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire isg_pkg::mac_req_t req,
  input  wire logic [32:0]      a,
  input  wire logic [32:0]      b,
  output logic [95:0]           acc
);
  import isg_pkg::*;

  logic [65:0] prod;
  logic        pv;
  logic        pclr;
  logic        psh;
  logic [95:0] addend;

  assign addend = psh ? {prod[63:0], 32'd0} : {30'd0, prod};

  always_ff @(posedge clk) begin
    prod <= a * b;
    pclr <= req.clr;
    psh  <= req.sh32;
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= req.go;
    end
    if (pv) begin
      acc <= (pclr ? 96'd0 : acc) + addend;
    end
  end
endmodule
`default_nettype wire

// ----- sv/inverse_square_gravity_sum_core.sv -----
// Top level of the inverse-square gravity accumulator: attractor table,
// sequencer, and the shared divide/sqrt and multiply units. Depends on isg_pkg.
`default_nettype none
// Usage: raise start with func for one cycle while busy is low. A write or
// clear item updates the table slot at that edge and never raises busy; slots
// at or beyond MAX_ATTRACTORS and func code 3 are dropped. An evaluate item
// raises busy; the block then scans every slot and works on each valid,
// enabled attractor with the single one-bit-per-cycle divide/sqrt unit (a
// 64-step divide, a 32-step root and three 31-step divides per term). The
// output phase follows (one normalizing shift per cycle, a root and three
// 16-step divides). The result is on the force and dir ports for exactly one
// cycle with done high, in the cycle busy falls; the receiver cannot stall it,
// so capture it then. The ports hold the values until the next evaluate item
// reaches its output phase.
module inverse_square_gravity_sum_core #(
  parameter int MAX_ATTRACTORS = isg_pkg::MAX_ATTRACTORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [3:0]         slot,
  input  wire logic               attractor_enable,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [31:0]        strength,
  input  wire logic [15:0]        body_mass,
  output logic                    done,
  output logic signed [47:0]      force_x,
  output logic signed [47:0]      force_y,
  output logic signed [47:0]      force_z,
  output logic signed [15:0]      dir_x,
  output logic signed [15:0]      dir_y,
  output logic signed [15:0]      dir_z
);
  import isg_pkg::*;

  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam int KW = IW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_IDIV  = 4'd4;
  localparam logic [3:0] S_ISQRT = 4'd5;
  localparam logic [3:0] S_UDIV  = 4'd6;
  localparam logic [3:0] S_UMUL  = 4'd7;
  localparam logic [3:0] S_FMUL  = 4'd8;
  localparam logic [3:0] S_MX    = 4'd9;
  localparam logic [3:0] S_NORM  = 4'd10;
  localparam logic [3:0] S_DSQ   = 4'd11;
  localparam logic [3:0] S_DSQRT = 4'd12;
  localparam logic [3:0] S_DDIV  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic signed [64:0] ACC_LIM = 65'sd1 <<< 62;

  // attractor table: flags in flops, payload in a small memory
  logic [1:0]  flags [MAX_ATTRACTORS];
  logic [31:0] mem_px [MAX_ATTRACTORS];
  logic [31:0] mem_py [MAX_ATTRACTORS];
  logic [31:0] mem_pz [MAX_ATTRACTORS];
  logic [31:0] mem_st [MAX_ATTRACTORS];
  logic [31:0] rdp [3];
  logic [31:0] rd_st;

  logic [3:0]    state;
  logic [KW-1:0] k;
  logic [1:0]    c;
  logic [2:0]    j;
  logic          issued;
  logic          accept;
  logic          slot_ok;
  logic [IW-1:0] waddr;
  logic [IW-1:0] kidx;

  logic signed [31:0] body [3];
  logic [15:0]        mass;
  logic               dneg [3];
  logic [32:0]        ad [3];
  logic [63:0]        s_reg;
  logic [63:0]        ival;
  logic [31:0]        rt;
  logic [30:0]        u;
  logic signed [63:0] acc_sum [3];
  logic [62:0]        mag [3];
  logic [62:0]        mx;
  logic signed [47:0] frc [3];
  logic signed [15:0] dir [3];

  iter_req_t   it_req;
  logic [63:0] it_a;
  logic [63:0] it_b;
  logic        it_done;
  logic [63:0] it_res;
  mac_req_t    mc_req;
  logic [32:0] mc_a;
  logic [32:0] mc_b;
  logic [95:0] mc_acc;

  logic [1:0]         idx;
  logic [32:0]        ad_i;
  logic [62:0]        mag_i;
  logic signed [63:0] as_i;
  logic [62:0]        m_i;
  logic [57:0]        term;
  logic signed [64:0] tsum;
  logic [62:0]        fval;
  logic [62:0]        mxw;
  logic [30:0]        uq;
  logic [15:0]        dq16;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = (32'(slot) < MAX_ATTRACTORS);
  assign waddr   = IW'(slot);
  assign kidx    = k[IW-1:0];

  assign force_x = frc[0];
  assign force_y = frc[1];
  assign force_z = frc[2];
  assign dir_x   = dir[0];
  assign dir_y   = dir[1];
  assign dir_z   = dir[2];

  // one operand index for the whole datapath: j while squaring, else the axis
  assign idx   = ((state == S_SQ || state == S_DSQ) && j < 3'd3) ? j[1:0] : c;
  assign ad_i  = ad[idx];
  assign mag_i = mag[idx];
  assign as_i  = acc_sum[idx];
  assign m_i   = as_i[63] ? 63'(-as_i) : as_i[62:0];
  assign term  = mc_acc[95:38];
  assign tsum  = {as_i[63], as_i} +
                 (dneg[c] ? -$signed({7'd0, term}) : $signed({7'd0, term}));
  assign fval  = mc_acc[78:16];
  assign uq    = (it_res[30:0] > 31'(32'd1 << 30)) ? 31'(32'd1 << 30) : it_res[30:0];
  assign dq16  = it_res[15:0];

  always_comb begin
    mxw = mag[0];
    if (mag[1] > mxw) mxw = mag[1];
    if (mag[2] > mxw) mxw = mag[2];
  end

  // operand select for the shared divide/sqrt unit
  always_comb begin
    it_req.go = 1'b0;
    it_req.op = OP_DIV;
    it_req.n  = 7'd64;
    it_a      = '0;
    it_b      = {32'd0, rt};
    case (state)
      S_IDIV: begin
        it_req.go = !issued;
        it_a      = {rd_st, 32'd0};
        it_b      = s_reg;
      end
      S_ISQRT, S_DSQRT: begin
        it_req.go = !issued;
        it_req.op = OP_SQRT;
        it_a      = s_reg;
      end
      S_UDIV: begin
        it_req.go = !issued;
        it_req.n  = 7'd31;
        it_a      = 64'({ad_i, 30'd0});
      end
      S_DDIV: begin
        it_req.go = !issued;
        it_req.n  = 7'd16;
        it_a      = 64'({mag_i[30:0], 15'd0});
      end
      default: begin
        it_req.go = 1'b0;
      end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mc_req.go   = 1'b0;
    mc_req.clr  = (j == 3'd0);
    mc_req.sh32 = (j == 3'd1);
    mc_a        = ad_i;
    mc_b        = ad_i;
    case (state)
      S_SQ: begin
        mc_req.go   = (j < 3'd3);
        mc_req.sh32 = 1'b0;
      end
      S_DSQ: begin
        mc_req.go   = (j < 3'd3);
        mc_req.sh32 = 1'b0;
        mc_a        = {2'd0, mag_i[30:0]};
        mc_b        = {2'd0, mag_i[30:0]};
      end
      S_UMUL: begin
        mc_req.go = (j < 3'd2);
        mc_a      = (j == 3'd0) ? {1'b0, ival[31:0]} : {1'b0, ival[63:32]};
        mc_b      = {2'd0, u};
      end
      S_FMUL: begin
        mc_req.go = (j < 3'd2);
        mc_a      = (j == 3'd0) ? {1'b0, m_i[31:0]} : {2'd0, m_i[62:32]};
        mc_b      = {17'd0, mass};
      end
      default: begin
        mc_req.go = 1'b0;
      end
    endcase
  end

  isg_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (it_req),
    .a    (it_a),
    .b    (it_b),
    .done (it_done),
    .res  (it_res)
  );

  isg_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mc_req),
    .a   (mc_a),
    .b   (mc_b),
    .acc (mc_acc)
  );

  // table payload: write on an accepted write item, read slot k every cycle
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_WRITE && slot_ok) begin
      mem_px[waddr] <= pos_x;
      mem_py[waddr] <= pos_y;
      mem_pz[waddr] <= pos_z;
      mem_st[waddr] <= strength;
    end
    rdp[0] <= mem_px[kidx];
    rdp[1] <= mem_py[kidx];
    rdp[2] <= mem_pz[kidx];
    rd_st  <= mem_st[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      state  <= S_IDLE;
      issued <= 1'b0;
      k      <= '0;
      c      <= '0;
      j      <= '0;
      for (int i = 0; i < MAX_ATTRACTORS; i++) flags[i] <= 2'b00;
    end else begin
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          issued <= 1'b0;
          if (accept) begin
            case (func)
              FUNC_WRITE: if (slot_ok) flags[waddr] <= {attractor_enable, 1'b1};
              FUNC_CLEAR: if (slot_ok) flags[waddr] <= 2'b00;
              FUNC_EVAL: begin
                body[0] <= pos_x;
                body[1] <= pos_y;
                body[2] <= pos_z;
                mass    <= body_mass;
                for (int a = 0; a < 3; a++) acc_sum[a] <= '0;
                k     <= '0;
                state <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // hold k on a live slot so the registered payload read lands
          if (k == KW'(MAX_ATTRACTORS)) begin
            c     <= '0;
            j     <= '0;
            state <= S_FMUL;
          end else if (flags[kidx] == 2'b11) begin
            state <= S_DIFF;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DIFF: begin
          for (int a = 0; a < 3; a++) begin
            logic signed [32:0] dd;
            dd = $signed({rdp[a][31], rdp[a]}) - $signed({body[a][31], body[a]});
            dneg[a] <= dd[32];
            ad[a]   <= dd[32] ? 33'(-dd) : 33'(dd);
          end
          j     <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          j <= j + 3'd1;
          if (j == 3'd4) begin
            // drop zero distance and squared lengths past 64 bits
            if (mc_acc[65:64] != 2'b00 || mc_acc[63:0] == 64'd0) begin
              k     <= k + 1'b1;
              state <= S_SCAN;
            end else begin
              s_reg <= mc_acc[63:0];
              state <= S_IDIV;
            end
          end
        end
        S_IDIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (it_done) begin
            issued <= 1'b0;
            ival   <= it_res;
            if (it_res == 64'd0) begin
              k     <= k + 1'b1;
              state <= S_SCAN;
            end else begin
              state <= S_ISQRT;
            end
          end
        end
        S_ISQRT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (it_done) begin
            issued <= 1'b0;
            rt     <= it_res[31:0];
            c      <= '0;
            state  <= S_UDIV;
          end
        end
        S_UDIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (it_done) begin
            issued <= 1'b0;
            u      <= uq;
            j      <= '0;
            state  <= S_UMUL;
          end
        end
        S_UMUL: begin
          j <= j + 3'd1;
          if (j == 3'd3) begin
            if (tsum > ACC_LIM) begin
              acc_sum[c] <= 64'(ACC_LIM);
            end else if (tsum < -ACC_LIM) begin
              acc_sum[c] <= 64'(-ACC_LIM);
            end else begin
              acc_sum[c] <= tsum[63:0];
            end
            if (c == 2'd2) begin
              k     <= k + 1'b1;
              state <= S_SCAN;
            end else begin
              c     <= c + 2'd1;
              state <= S_UDIV;
            end
          end
        end
        S_FMUL: begin
          if (j == 3'd3) begin
            j      <= '0;
            mag[c] <= m_i;
            if (as_i[63]) begin
              frc[c] <= (fval > 63'(64'd1 << 47)) ? 48'sh8000_0000_0000 : -$signed(fval[47:0]);
            end else begin
              frc[c] <= (fval > 63'((64'd1 << 47) - 64'd1)) ? 48'sh7FFF_FFFF_FFFF
                                                            : $signed(fval[47:0]);
            end
            if (c == 2'd2) begin
              state <= S_MX;
            end else begin
              c <= c + 2'd1;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
        S_MX: begin
          if (mxw == 63'd0) begin
            for (int a = 0; a < 3; a++) dir[a] <= '0;
            state <= S_OUT;
          end else begin
            mx    <= mxw;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // one shift per cycle until the largest magnitude sits in [2^30, 2^31)
          if (mx[62:31] != '0) begin
            mx <= mx >> 1;
            for (int a = 0; a < 3; a++) mag[a] <= mag[a] >> 1;
          end else if (!mx[30]) begin
            mx <= mx << 1;
            for (int a = 0; a < 3; a++) mag[a] <= mag[a] << 1;
          end else begin
            j     <= '0;
            state <= S_DSQ;
          end
        end
        S_DSQ: begin
          j <= j + 3'd1;
          if (j == 3'd4) begin
            s_reg <= mc_acc[63:0];
            state <= S_DSQRT;
          end
        end
        S_DSQRT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (it_done) begin
            issued <= 1'b0;
            rt     <= it_res[31:0];
            c      <= '0;
            state  <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (it_done) begin
            issued <= 1'b0;
            if (as_i[63]) begin
              dir[c] <= (dq16 > 16'd32768) ? 16'sh8000 : -$signed(dq16);
            end else begin
              dir[c] <= (dq16 > 16'd32767) ? 16'sh7FFF : $signed(dq16);
            end
            if (c == 2'd2) begin
              state <= S_OUT;
            end else begin
              c <= c + 2'd1;
            end
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/isg_chk.sv -----
// Port-level checker for inverse_square_gravity_sum_core, bound to the top.
// Depends on isg_pkg.
`default_nettype none
module isg_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] func,
  input wire logic       done
);
  import isg_pkg::*;

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_EVAL) |=> busy)
    else $error("evaluate item did not raise busy");

  a_table_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != FUNC_EVAL) |=> (!busy && !done))
    else $error("table item started work or gave a result");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result not at end of evaluation");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("evaluation ended without result");
endmodule

bind inverse_square_gravity_sum_core isg_chk u_isg_chk (.*);
`default_nettype wire

// ----- tb/tb_inverse_square_gravity_sum_core.sv -----
// Self-checking bench for inverse_square_gravity_sum_core: random attractor tables and
// bodies are driven through the command port, and every done strobe is compared with
// an in-bench fixed-point gravity predictor. Depends on isg_pkg and the core.
`default_nettype none
module tb_inverse_square_gravity_sum_core;
  import isg_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam longint ACC_LIMIT = 64'sd1 << 62;
  localparam longint FORCE_MAX = (64'sd1 << 47) - 1;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  typedef struct {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic        enable;
    logic [31:0] px, py, pz;
    logic [31:0] strength;
    logic [15:0] mass;
  } cmd_item_t;

  typedef struct {
    logic [47:0] fx, fy, fz;
    logic [15:0] dx, dy, dz;
  } gravity_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = '0;
  logic [3:0] slot = '0;
  logic attractor_enable = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] strength = '0;
  logic [15:0] body_mass = '0;
  logic busy, done;
  logic signed [47:0] force_x, force_y, force_z;
  logic signed [15:0] dir_x, dir_y, dir_z;

  inverse_square_gravity_sum_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .attractor_enable(attractor_enable), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .strength(strength), .body_mass(body_mass), .done(done),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the attractor table.
  logic        tbl_valid [NUM_SLOTS];
  logic        tbl_enable[NUM_SLOTS];
  logic [31:0] tbl_pos   [NUM_SLOTS][3];
  logic [31:0] tbl_str   [NUM_SLOTS];

  cmd_item_t    pending_cmds[$];
  gravity_out_t expected_forces[$];
  int  idle_pct = 0;
  int  errors = 0;
  longint cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Apply one item to the table model; return 1 with the expected result on evaluate.
  function automatic bit predict_gravity(input cmd_item_t it, output gravity_out_t r);
    longint acc[3], body[3], d[3];
    logic [63:0] ad[3], mag[3], s, sq, inten, rt, u, term, m, f, mx, sum, q;
    logic [127:0] wide;
    bit over;
    longint fv;
    int dv;
    logic [47:0] fo[3];
    logic [15:0] dout[3];
    r = '{default: '0};
    if (it.func == FUNC_WRITE || it.func == FUNC_CLEAR) begin
      if (it.func == FUNC_WRITE) begin
        tbl_valid[it.slot] = 1'b1;
        tbl_enable[it.slot] = it.enable;
        tbl_pos[it.slot][0] = it.px;
        tbl_pos[it.slot][1] = it.py;
        tbl_pos[it.slot][2] = it.pz;
        tbl_str[it.slot] = it.strength;
      end else begin
        tbl_valid[it.slot] = 1'b0;
        tbl_enable[it.slot] = 1'b0;
      end
      return 1'b0;
    end
    if (it.func != FUNC_EVAL) return 1'b0;
    body[0] = longint'(signed'(it.px));
    body[1] = longint'(signed'(it.py));
    body[2] = longint'(signed'(it.pz));
    acc = '{0, 0, 0};
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (!(tbl_valid[k] && tbl_enable[k])) continue;
      s = 0;
      over = 1'b0;
      for (int c = 0; c < 3; c++) begin
        d[c] = longint'(signed'(tbl_pos[k][c])) - body[c];
        ad[c] = d[c] < 0 ? -d[c] : d[c];
        sq = ad[c] * ad[c];
        if (s + sq < s) over = 1'b1;
        s += sq;
      end
      if (over || s == 0) continue;
      inten = {tbl_str[k], 32'd0} / s;
      if (inten == 0) continue;
      rt = int_sqrt(s);
      for (int c = 0; c < 3; c++) begin
        u = (ad[c] << 30) / rt;
        if (u > (64'd1 << 30)) u = 64'd1 << 30;
        wide = 128'(inten) * 128'(u);
        term = 64'(wide >> 38);
        acc[c] = acc[c] + (d[c] < 0 ? -longint'(term) : longint'(term));
        if (acc[c] > ACC_LIMIT) acc[c] = ACC_LIMIT;
        if (acc[c] < -ACC_LIMIT) acc[c] = -ACC_LIMIT;
      end
    end
    mx = 0;
    for (int c = 0; c < 3; c++) begin
      m = acc[c] < 0 ? -acc[c] : acc[c];
      f = (m >> 16) * it.mass + (((m & 64'hFFFF) * it.mass) >> 16);
      mag[c] = m;
      if (m > mx) mx = m;
      if (acc[c] < 0) fv = (f > FORCE_MAX + 1) ? -FORCE_MAX - 1 : -longint'(f);
      else fv = (f > FORCE_MAX) ? FORCE_MAX : longint'(f);
      fo[c] = fv[47:0];
      dout[c] = '0;
    end
    if (mx != 0) begin
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1;
        for (int c = 0; c < 3; c++) mag[c] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int c = 0; c < 3; c++) mag[c] <<= 1;
      end
      sum = 0;
      for (int c = 0; c < 3; c++) sum += mag[c] * mag[c];
      rt = int_sqrt(sum);
      for (int c = 0; c < 3; c++) begin
        q = (mag[c] << 15) / rt;
        if (acc[c] < 0) dv = q > 32768 ? -32768 : -int'(q);
        else dv = q > 32767 ? 32767 : int'(q);
        dout[c] = dv[15:0];
      end
    end
    r.fx = fo[0]; r.fy = fo[1]; r.fz = fo[2];
    r.dx = dout[0]; r.dy = dout[1]; r.dz = dout[2];
    return 1'b1;
  endfunction

  // Driver: hold start while busy; advance on each accepted item.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
      end
      if (start && busy) begin
        // hold the item until accepted
      end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cmd_item_t it;
        it = pending_cmds[0];
        start <= 1'b1;
        func <= it.func;
        slot <= it.slot;
        attractor_enable <= it.enable;
        pos_x <= it.px;
        pos_y <= it.py;
        pos_z <= it.pz;
        strength <= it.strength;
        body_mass <= it.mass;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict at acceptance: the model sees items in the order the block does.
  always @(posedge clk) begin
    gravity_out_t r;
    if (!rst && start && !busy) begin
      cmd_item_t it;
      it.func = func; it.slot = slot; it.enable = attractor_enable;
      it.px = pos_x; it.py = pos_y; it.pz = pos_z;
      it.strength = strength; it.mass = body_mass;
      if (predict_gravity(it, r)) expected_forces.push_back(r);
    end
  end

  // Monitor: compare each done strobe with the oldest expected result.
  always @(posedge clk) begin
    gravity_out_t e;
    if (!rst && done) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result force_x=%h", force_x);
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (force_x !== e.fx) begin
          $error("force_x exp %h got %h", e.fx, force_x); errors++;
        end
        if (force_y !== e.fy) begin
          $error("force_y exp %h got %h", e.fy, force_y); errors++;
        end
        if (force_z !== e.fz) begin
          $error("force_z exp %h got %h", e.fz, force_z); errors++;
        end
        if (dir_x !== e.dx) begin
          $error("dir_x exp %h got %h", e.dx, dir_x); errors++;
        end
        if (dir_y !== e.dy) begin
          $error("dir_y exp %h got %h", e.dy, dir_y); errors++;
        end
        if (dir_z !== e.dz) begin
          $error("dir_z exp %h got %h", e.dz, dir_z); errors++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_inverse_square_gravity_sum_core failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pos(input int near);
    // Mostly clustered coordinates so terms stay significant; sometimes full range.
    if ($urandom_range(9) == 0) return $urandom;
    return 32'(near + int'($urandom_range(8000)) - 4000);
  endfunction

  function automatic cmd_item_t make_cmd(input logic [1:0] f, input logic [3:0] sl,
                                         input logic en, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [31:0] st, input logic [15:0] ms);
    cmd_item_t it;
    it.func = f; it.slot = sl; it.enable = en;
    it.px = x; it.py = y; it.pz = z; it.strength = st; it.mass = ms;
    return it;
  endfunction

  task automatic push_random(input int count);
    cmd_item_t it;
    int sel, near;
    for (int i = 0; i < count; i++) begin
      near = int'($urandom_range(200000)) - 100000;
      sel = $urandom_range(99);
      it = make_cmd(FUNC_EVAL, 4'($urandom), 1'($urandom), rand_pos(near), rand_pos(near),
                    rand_pos(near), $urandom, 16'($urandom));
      if (sel < 40) begin
        it.func = FUNC_WRITE;
        it.enable = ($urandom_range(9) != 0);
        if ($urandom_range(3) == 0) it.strength = $urandom_range(65535);
      end else if (sel < 50) begin
        it.func = FUNC_CLEAR;
      end else if (sel < 53) begin
        it.func = 2'd3;
      end
      if (it.func == FUNC_EVAL) begin
        it.px = rand_pos(0); it.py = rand_pos(0); it.pz = rand_pos(0);
      end
      pending_cmds.push_back(it);
    end
  endtask

  task automatic wait_drained;
    while (pending_cmds.size() != 0 || expected_forces.size() != 0 || start || busy)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_enable[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty table, extremes, zero distance, negligible, disabled, func 3.
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 0, 1, 32'h100, 0, 0, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 15, 1, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h0001_0000, 0));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 32'h100, 0, 0, 0, 16'd1));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 0, 16'd0));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 3, 0, 32'h200, 32'h200, 0,
                                    32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(FUNC_WRITE, 4, 1, 32'h7FFF_FFFF, 0, 0, 32'h1, 0));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 32'hFFFF_FF00, 32'h80, 32'h40, 0,
                                    16'h8000));
    pending_cmds.push_back(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(2'd3, 5, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 16'h1234));
    pending_cmds.push_back(make_cmd(FUNC_CLEAR, 15, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    wait_drained();
    // Random phases: no idling, heavy sender idling, moderate idling.
    idle_pct = 0;  push_random(250); wait_drained();
    idle_pct = 80; push_random(250); wait_drained();
    idle_pct = 28; push_random(250); wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("tb_inverse_square_gravity_sum_core passed");
    end else begin
      $display("tb_inverse_square_gravity_sum_core failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
